FILE: sv/pcpq_pkg.sv
`timescale 1ns / 1ps

package pcpq_pkg;

    localparam int SQRT_BITS       = 33;   // root bits of the 66 bit radicand
    localparam int SQRT_STEPS_DEF  = 4;    // root bits resolved per sqrt stage
    localparam int CFG_IDX_W       = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AXLEN   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 8'd7;

    localparam logic [31:0] DIR_ONE   = 32'h4000_0000;
    localparam logic [30:0] LEN_ONE   = 31'h0001_0000;
    localparam logic [30:0] RAD_ONE   = 31'h0001_0000;

    typedef struct packed {
        logic [2:0][31:0] start;
        logic [2:0][31:0] dir;
        logic [30:0]      axial_length;
        logic [30:0]      patch_radius;
    } t_cfg;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [30:0]      tol;
        logic [36:0]      s;
        logic [31:0]      ssat;
    } t_proj;

    typedef struct packed {
        logic [36:0]      s;
        logic [2:0][34:0] foot;
        logic [30:0]      tol;
        logic             far;
    } t_meta;

    function automatic logic [31:0] sat32(input logic signed [39:0] x);
        logic [31:0] r;
        if (x > 40'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (x < -40'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/pcpq_proj.sv
`timescale 1ns / 1ps

// offset, dot product with tangent, rounding of s
module pcpq_proj (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcpq_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0][31:0]    i_p,
    input  logic [30:0]         i_tol,
    output logic                o_valid,
    input  logic                i_ready,
    output pcpq_pkg::t_proj     o_data
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;
    logic signed [2:0][32:0] r_d;
    logic signed [2:0][64:0] r_prod;
    logic [2:0][31:0] r_p1, r_p2;
    logic [30:0] r_tol1, r_tol2;
    pcpq_pkg::t_proj r_out;
    logic signed [66:0] w_sum;
    logic signed [66:0] w_rnd;
    logic [36:0] w_s;

    assign en3 = !r_v3 || i_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    always_comb begin
        w_sum = {{2{r_prod[0][64]}}, r_prod[0]} + {{2{r_prod[1][64]}}, r_prod[1]}
              + {{2{r_prod[2][64]}}, r_prod[2]};
        w_rnd = w_sum + 67'sd536870912;
        w_s   = w_rnd[66:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= {i_p[i][31], i_p[i]} - {i_cfg.start[i][31], i_cfg.start[i]};
            end
            r_p1   <= i_p;
            r_tol1 <= i_tol;
        end
        if (en2) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= $signed(r_d[i]) * $signed(i_cfg.dir[i]);
            end
            r_p2   <= r_p1;
            r_tol2 <= r_tol1;
        end
        if (en3) begin
            r_out.p    <= r_p2;
            r_out.tol  <= r_tol2;
            r_out.s    <= w_s;
            r_out.ssat <= pcpq_pkg::sat32({{3{w_s[36]}}, w_s});
        end
    end

endmodule

FILE: sv/pcpq_foot.sv
`timescale 1ns / 1ps

// foot point, residual, squares and their sum
module pcpq_foot (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcpq_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  pcpq_pkg::t_proj     i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output pcpq_pkg::t_meta     o_meta,
    output logic [65:0]         o_rad
);

    logic r_v4, r_v5, r_v6, r_v7;
    logic en4, en5, en6, en7;
    logic signed [2:0][63:0] r_prod;
    pcpq_pkg::t_proj r_q4;
    pcpq_pkg::t_meta r_m5, r_m6, r_m7;
    logic [2:0][31:0] r_mag;
    logic [2:0][63:0] r_sq;
    logic [65:0] r_rad;
    logic signed [2:0][34:0] w_foot;
    logic [2:0][35:0] w_mag;
    logic [2:0] w_far;
    logic signed [35:0] w_res;

    assign en7 = !r_v7 || i_ready;
    assign en6 = !r_v6 || en7;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign o_ready = en4;
    assign o_valid = r_v7;
    assign o_meta  = r_m7;
    assign o_rad   = r_rad;

    always_comb begin
        w_res = '0;
        for (int i = 0; i < 3; i++) begin
            // round half up: floor of the product over 2^30 plus bit 29
            w_foot[i] = {{3{i_cfg.start[i][31]}}, i_cfg.start[i]}
                      + {r_prod[i][63], r_prod[i][63:30]} + {34'd0, r_prod[i][29]};
            w_res     = {{4{r_q4.p[i][31]}}, r_q4.p[i]} - {w_foot[i][34], w_foot[i]};
            w_mag[i]  = w_res[35] ? -w_res : w_res;
            w_far[i]  = |w_mag[i][35:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
            if (en7) r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= $signed(i_data.ssat) * $signed(i_cfg.dir[i]);
            end
            r_q4 <= i_data;
        end
        if (en5) begin
            r_m5.s    <= r_q4.s;
            r_m5.foot <= w_foot;
            r_m5.tol  <= r_q4.tol;
            r_m5.far  <= |w_far;
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= w_far[i] ? 32'h0 : w_mag[i][31:0];
            end
        end
        if (en6) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_mag[i] * r_mag[i];
            end
            r_m6 <= r_m5;
        end
        if (en7) begin
            r_rad <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
            r_m7  <= r_m6;
        end
    end

endmodule

FILE: sv/pcpq_sqrt.sv
`timescale 1ns / 1ps

// pipelined digit-by-digit square root, several root bits per stage
module pcpq_sqrt #(
    parameter int P_STEPS = pcpq_pkg::SQRT_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [65:0]         i_rad,
    input  pcpq_pkg::t_meta     i_meta,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [32:0]         o_root,
    output pcpq_pkg::t_meta     o_meta
);

    localparam int NST = (pcpq_pkg::SQRT_BITS + P_STEPS - 1) / P_STEPS;

    logic [NST-1:0] r_v;
    logic [NST:0]   en;
    logic [34:0] r_rem  [NST];
    logic [32:0] r_root [NST];
    logic [65:0] r_rad  [NST];
    pcpq_pkg::t_meta r_meta [NST];
    logic [34:0] n_rem  [NST];
    logic [32:0] n_root [NST];
    logic [65:0] n_rad  [NST];
    // what each stage takes in
    logic [34:0] w_prem  [NST];
    logic [32:0] w_proot [NST];
    logic [65:0] w_prad  [NST];
    pcpq_pkg::t_meta w_pmeta [NST];
    logic [NST-1:0] w_pv;

    always_comb begin
        en[NST] = i_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];
    assign o_root  = r_root[NST-1];
    assign o_meta  = r_meta[NST-1];

    always_comb begin
        w_prem[0]  = '0;
        w_proot[0] = '0;
        w_prad[0]  = i_rad;
        w_pmeta[0] = i_meta;
        w_pv[0]    = i_valid;
        for (int k = 1; k < NST; k++) begin
            w_prem[k]  = r_rem[k-1];
            w_proot[k] = r_root[k-1];
            w_prad[k]  = r_rad[k-1];
            w_pmeta[k] = r_meta[k-1];
            w_pv[k]    = r_v[k-1];
        end
    end

    always_comb begin
        logic [36:0] w_rem;
        logic [34:0] w_trial;
        logic [32:0] w_root;
        logic [65:0] w_rad;
        for (int k = 0; k < NST; k++) begin
            w_rem  = {2'b00, w_prem[k]};
            w_root = w_proot[k];
            w_rad  = w_prad[k];
            for (int j = 0; j < P_STEPS; j++) begin
                if (k * P_STEPS + j < pcpq_pkg::SQRT_BITS) begin
                    w_rem   = {w_rem[34:0], w_rad[65:64]};
                    w_rad   = {w_rad[63:0], 2'b00};
                    w_trial = {w_root[32:0], 2'b01};
                    w_root  = {w_root[31:0], 1'b0};
                    if (w_rem >= {2'b00, w_trial}) begin
                        w_rem     = w_rem - {2'b00, w_trial};
                        w_root[0] = 1'b1;
                    end
                end
            end
            n_rem[k]  = w_rem[34:0];
            n_root[k] = w_root;
            n_rad[k]  = w_rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) r_v[k] <= w_pv[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_meta[k] <= w_pmeta[k];
            end
        end
    end

endmodule

FILE: sv/point_cylinder_patch_query.sv
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// s_axis    in         i_s_tvalid / o_s_tready    point_x, point_y, point_z, tol
// m_axis    out        o_m_tvalid / i_m_tready    s, rho, foot x/y/z, rho - radius, inside
// cfg       in         i_cfg_valid / o_cfg_ready  register index, write data
//
// one point per cycle sustained; 7 + ceil(33 / P_SQRT_STEPS) + 1 register stages: the proj and
// foot stages, which hold the two multiply rounds and the square-of-residual round, the sqrt
// stages and the output register.
// every stage holds its own valid bit and moves when the next one has room, so bubbles
// close up and a stall on m_axis holds every beat in place.
// synchronous active-low reset clears the valid bits and loads the default patch.
module point_cylinder_patch_query #(
    parameter int P_SQRT_STEPS = pcpq_pkg::SQRT_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // point_x [31:0], point_y [63:32], point_z [95:64], tol [126:96], zero [127]
    input  logic [127:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // axial_coord [31:0], radial_dist [62:32], foot_x [94:63], foot_y [126:95],
    // foot_z [158:127], signed_radial [190:159], inside_res [191]
    output logic [191:0] o_m_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [pcpq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    pcpq_pkg::t_cfg  r_cfg;
    pcpq_pkg::t_proj w_proj;
    pcpq_pkg::t_meta w_fmeta, w_smeta;
    logic [2:0][31:0] w_p;
    logic [65:0] w_rad;
    logic [32:0] w_root;
    logic w_pv, w_pr, w_fv, w_fr, w_sv, w_sr;
    logic r_ov;
    logic [191:0] r_out;
    logic en_out;

    logic [32:0] w_rho;
    logic signed [38:0] w_s, w_tol, w_hi;
    logic [33:0] w_rho_w, w_radtol;
    logic signed [33:0] w_diff;
    logic w_inside;
    logic [30:0] w_radial;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start        <= '0;
            r_cfg.dir[0]       <= pcpq_pkg::DIR_ONE;
            r_cfg.dir[1]       <= '0;
            r_cfg.dir[2]       <= '0;
            r_cfg.axial_length <= pcpq_pkg::LEN_ONE;
            r_cfg.patch_radius <= pcpq_pkg::RAD_ONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pcpq_pkg::CFG_START_X: r_cfg.start[0]     <= i_cfg_data;
                pcpq_pkg::CFG_START_Y: r_cfg.start[1]     <= i_cfg_data;
                pcpq_pkg::CFG_START_Z: r_cfg.start[2]     <= i_cfg_data;
                pcpq_pkg::CFG_DIR_X:   r_cfg.dir[0]       <= i_cfg_data;
                pcpq_pkg::CFG_DIR_Y:   r_cfg.dir[1]       <= i_cfg_data;
                pcpq_pkg::CFG_DIR_Z:   r_cfg.dir[2]       <= i_cfg_data;
                pcpq_pkg::CFG_AXLEN:   r_cfg.axial_length <= i_cfg_data[30:0];
                pcpq_pkg::CFG_RADIUS:  r_cfg.patch_radius <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign w_p[0] = i_s_tdata[31:0];
    assign w_p[1] = i_s_tdata[63:32];
    assign w_p[2] = i_s_tdata[95:64];

    pcpq_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_p     (w_p),
        .i_tol   (i_s_tdata[126:96]),
        .o_valid (w_pv),
        .i_ready (w_pr),
        .o_data  (w_proj)
    );

    pcpq_foot u_foot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_pv),
        .o_ready (w_pr),
        .i_data  (w_proj),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_meta  (w_fmeta),
        .o_rad   (w_rad)
    );

    pcpq_sqrt #(.P_STEPS(P_SQRT_STEPS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_rad   (w_rad),
        .i_meta  (w_fmeta),
        .o_valid (w_sv),
        .i_ready (w_sr),
        .o_root  (w_root),
        .o_meta  (w_smeta)
    );

    assign en_out = !r_ov || i_m_tready;
    assign w_sr   = en_out;

    always_comb begin
        // a far residual stands for rho of 2^32
        w_rho    = w_smeta.far ? 33'h1_0000_0000 : w_root;
        w_rho_w  = {1'b0, w_rho};
        w_s      = {{2{w_smeta.s[36]}}, w_smeta.s};
        w_tol    = {8'd0, w_smeta.tol};
        w_hi     = {8'd0, r_cfg.axial_length} + w_tol;
        w_radtol = {3'd0, r_cfg.patch_radius} + {3'd0, w_smeta.tol};
        w_diff   = $signed(w_rho_w) - $signed({3'd0, r_cfg.patch_radius});
        w_inside = (w_s >= -w_tol) && (w_s <= w_hi)
                && (w_rho_w > {3'd0, w_smeta.tol}) && (w_rho_w <= w_radtol);
        w_radial = (w_rho > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : w_rho[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= w_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out[31:0]    <= pcpq_pkg::sat32({{3{w_smeta.s[36]}}, w_smeta.s});
            r_out[62:32]   <= w_radial;
            r_out[94:63]   <= pcpq_pkg::sat32({{5{w_smeta.foot[0][34]}}, w_smeta.foot[0]});
            r_out[126:95]  <= pcpq_pkg::sat32({{5{w_smeta.foot[1][34]}}, w_smeta.foot[1]});
            r_out[158:127] <= pcpq_pkg::sat32({{5{w_smeta.foot[2][34]}}, w_smeta.foot[2]});
            r_out[190:159] <= pcpq_pkg::sat32({{6{w_diff[33]}}, w_diff});
            r_out[191]     <= w_inside;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out;

endmodule

FILE: dv/point_cylinder_patch_query_test.sv
`timescale 1ns / 1ps

module point_cylinder_patch_query_test;

    localparam int IDX_W = pcpq_pkg::CFG_IDX_W;
    // indexes that name no register
    localparam logic [IDX_W-1:0] CFG_NONE_LO = 8'd8;
    localparam logic [IDX_W-1:0] CFG_NONE_HI = 8'hFF;

    typedef struct packed {
        logic        in_patch;
        logic [31:0] signed_radial;
        logic [31:0] foot_z;
        logic [31:0] foot_y;
        logic [31:0] foot_x;
        logic [30:0] radial_dist;
        logic [31:0] axial_coord;
    } t_query_res;

    // patch registers held by the predictor
    longint pat_start [3];
    longint pat_dir [3];
    longint pat_len;
    longint pat_rad;

    function automatic longint floor_sh(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // floor square root of a 66 bit radicand
    function automatic longint root66(logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [33:0] root;
        rem = 0;
        root = 0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | v[2*i +: 2];
            trial = {root, 2'b01};
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root[0] = 1'b1;
            end
        end
        return longint'(root);
    endfunction

    function automatic t_query_res predict_query(logic [127:0] d);
        longint pt [3];
        longint off [3];
        longint foot [3];
        longint a, b, alow, s, ssat, rho, tol, th, r;
        logic [65:0] acc;
        logic [63:0] m;
        bit far;
        bit ins;
        t_query_res q;
        a = 0; b = 0; acc = 0; far = 0;
        pt[0] = longint'($signed(d[31:0]));
        pt[1] = longint'($signed(d[63:32]));
        pt[2] = longint'($signed(d[95:64]));
        tol = longint'(d[126:96]);
        for (int i = 0; i < 3; i++) begin
            th = floor_sh(pat_dir[i], 15);
            off[i] = pt[i] - pat_start[i];
            a += off[i] * th;
            b += off[i] * (pat_dir[i] - th * 32768);
        end
        alow = a - floor_sh(a, 15) * 32768;
        s = floor_sh(a, 15) + floor_sh(alow * 32768 + b + 64'sd536870912, 30);
        ssat = clamp32(s);
        for (int i = 0; i < 3; i++) begin
            foot[i] = pat_start[i] + floor_sh(ssat * pat_dir[i] + 64'sd536870912, 30);
            r = pt[i] - foot[i];
            m = (r < 0) ? -r : r;
            if (m >= 64'd4294967296) far = 1;
            else acc += 66'(m * m);
        end
        rho = far ? 64'sd4294967296 : root66(acc);
        ins = s >= -tol && s <= pat_len + tol && rho > tol && rho <= pat_rad + tol;
        q.axial_coord = 32'(clamp32(s));
        q.radial_dist = (rho > 64'sd2147483647) ? 31'h7FFFFFFF : rho[30:0];
        q.foot_x = 32'(clamp32(foot[0]));
        q.foot_y = 32'(clamp32(foot[1]));
        q.foot_z = 32'(clamp32(foot[2]));
        q.signed_radial = 32'(clamp32(rho - pat_rad));
        q.in_patch = ins;
        return q;
    endfunction

    class query_board;
        t_query_res pending [$];
        int errors;
        int checked;
        int n_inside;

        function void note_point(t_query_res q);
            pending.insert(pending.size(), q);
        endfunction

        function void check_result(logic [191:0] raw);
            t_query_res got;
            t_query_res want;
            got = raw;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, raw);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.in_patch) n_inside++;
            if (got.axial_coord !== want.axial_coord) begin
                $display("%0t axial_coord exp %h got %h", $time, want.axial_coord,
                         got.axial_coord);
                errors++;
            end
            if (got.radial_dist !== want.radial_dist) begin
                $display("%0t radial_dist exp %h got %h", $time, want.radial_dist,
                         got.radial_dist);
                errors++;
            end
            if (got.foot_x !== want.foot_x) begin
                $display("%0t foot_x exp %h got %h", $time, want.foot_x, got.foot_x);
                errors++;
            end
            if (got.foot_y !== want.foot_y) begin
                $display("%0t foot_y exp %h got %h", $time, want.foot_y, got.foot_y);
                errors++;
            end
            if (got.foot_z !== want.foot_z) begin
                $display("%0t foot_z exp %h got %h", $time, want.foot_z, got.foot_z);
                errors++;
            end
            if (got.signed_radial !== want.signed_radial) begin
                $display("%0t signed_radial exp %h got %h", $time, want.signed_radial,
                         got.signed_radial);
                errors++;
            end
            if (got.in_patch !== want.in_patch) begin
                $display("%0t inside_res exp %b got %b", $time, want.in_patch,
                         got.in_patch);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [191:0] o_m_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index;
    logic [31:0]  i_cfg_data;

    point_cylinder_patch_query u_dut (.*);

    query_board board;
    bit rx_hold;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[point_cylinder_patch_query] ERROR");
        $finish;
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        @(posedge i_clk);
        case (idx)
            pcpq_pkg::CFG_START_X: pat_start[0] = longint'($signed(val));
            pcpq_pkg::CFG_START_Y: pat_start[1] = longint'($signed(val));
            pcpq_pkg::CFG_START_Z: pat_start[2] = longint'($signed(val));
            pcpq_pkg::CFG_DIR_X:   pat_dir[0] = longint'($signed(val));
            pcpq_pkg::CFG_DIR_Y:   pat_dir[1] = longint'($signed(val));
            pcpq_pkg::CFG_DIR_Z:   pat_dir[2] = longint'($signed(val));
            pcpq_pkg::CFG_AXLEN:   pat_len = longint'(val[30:0]);
            pcpq_pkg::CFG_RADIUS:  pat_rad = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [30:0] tol, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {1'b0, tol, z, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_point(predict_query({1'b0, tol, z, y, x}));
    endtask

    task automatic drain;
        i_s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1024 << 16)) - (512 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rnd_dir();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 32'h40000000 : 32'hC0000000;
            1: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
        endcase
    endfunction

    function automatic logic [30:0] rnd_len();
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 2));
            1: return 31'h7FFFFFFF;
            2: return 31'($urandom());
            default: return 31'($urandom_range(1, 64 << 16));
        endcase
    endfunction

    function automatic logic [30:0] rnd_tol();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 31'($urandom());
            default: return 31'($urandom_range(0, 1 << 16));
        endcase
    endfunction

    // one random patch, then points near it so the inside test gets hit often
    task automatic random_phase(int count);
        logic [31:0] c [3];
        for (int i = 0; i < 3; i++) write_reg(pcpq_pkg::CFG_START_X + IDX_W'(i), rnd_coord());
        for (int i = 0; i < 3; i++) write_reg(pcpq_pkg::CFG_DIR_X + IDX_W'(i), rnd_dir());
        write_reg(pcpq_pkg::CFG_AXLEN, {1'b0, rnd_len()});
        write_reg(pcpq_pkg::CFG_RADIUS, {1'b0, rnd_len()});
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 3; i++) begin
                if ($urandom_range(0, 3) == 0) c[i] = rnd_coord();
                else c[i] = 32'(pat_start[i]) + 32'($signed($urandom_range(0, 6 << 16))
                            - (3 << 16));
            end
            send_point(c[0], c[1], c[2], rnd_tol(), 0);
        end
        drain();
    endtask

    initial begin
        board = new();
        rx_hold = 0;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        pat_start = '{0, 0, 0};
        pat_dir = '{64'sd1073741824, 0, 0};
        pat_len = 65536;
        pat_rad = 65536;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset patch: axis along x, unit length and radius
        send_point(32'h00008000, 32'h00010000, 0, 0, 1);
        send_point(32'h00008000, 0, 0, 0, 1);
        send_point(32'h00008000, 32'h00008000, 0, 31'h00010000, 1);
        send_point(32'hFFFF0000, 32'h00010000, 0, 31'h00010000, 0);
        send_point(32'h00020000, 32'h00010000, 0, 0, 0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 0);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
        send_point(32'h80000000, 32'h7FFFFFFF, 0, 0, 0);
        send_point(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 31'h55555555, 0);
        send_point(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 31'h2AAAAAAA, 0);
        drain();
        // unknown index is ignored; far residual and non-unit tangent
        write_reg(CFG_NONE_LO, 32'hDEADBEEF);
        write_reg(CFG_NONE_HI, 32'h12345678);
        write_reg(pcpq_pkg::CFG_START_X, 32'h80000000);
        write_reg(pcpq_pkg::CFG_START_Y, 32'h7FFFFFFF);
        write_reg(pcpq_pkg::CFG_START_Z, 32'h80000000);
        write_reg(pcpq_pkg::CFG_DIR_X, 32'hC0000000);
        write_reg(pcpq_pkg::CFG_DIR_Y, 32'h40000000);
        write_reg(pcpq_pkg::CFG_DIR_Z, 32'hFFFFFFFF);
        write_reg(pcpq_pkg::CFG_AXLEN, 32'h7FFFFFFF);
        write_reg(pcpq_pkg::CFG_RADIUS, 32'h7FFFFFFF);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0);
        send_point(0, 0, 0, 31'h7FFFFFFF, 0);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0);
        drain();
        write_reg(pcpq_pkg::CFG_AXLEN, 0);
        write_reg(pcpq_pkg::CFG_RADIUS, 0);
        write_reg(pcpq_pkg::CFG_DIR_X, 0);
        write_reg(pcpq_pkg::CFG_DIR_Y, 0);
        write_reg(pcpq_pkg::CFG_DIR_Z, 0);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0);
        send_point(32'h00010000, 32'h00010000, 32'h00010000, 0, 0);
        drain();

        // long receiver stall while points keep coming
        rx_hold = 1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                rx_hold = 0;
            end
            random_phase(60);
        join

        for (int ph = 0; ph < 23; ph++) random_phase(60);
        drain();
        $display("checked %0d results over 27 patch settings, %0d inside the patch",
                 board.checked, board.n_inside);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[point_cylinder_patch_query] OK");
        end else begin
            $display("[point_cylinder_patch_query] ERROR");
        end
        $finish;
    end

    // receiver: random stalls per beat, plus the long hold
    initial begin
        int gap;
        i_m_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0 || rx_hold) begin
                i_m_tready <= 0;
                repeat (gap) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            i_m_tready <= 1;
            do @(posedge i_clk); while (!o_m_tvalid);
            board.check_result(o_m_tdata);
        end
    end
endmodule
